>>> rtl/tcse_pkg.sv
package tcse_pkg;

    // func codes on the command port
    localparam logic [2:0] FUNC_PUT    = 3'd0;
    localparam logic [2:0] FUNC_SCROLL = 3'd1;
    localparam logic [2:0] FUNC_SETCUR = 3'd2;
    localparam logic [2:0] FUNC_CLEAR  = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    // control characters
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0] ATTR_RESET = 8'd7;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_SCROLL,
        OP_SETCUR,
        OP_CLEAR,
        OP_READ,
        OP_NONE
    } op_t;

    // classified command word passed from front to back
    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        logic [12:0] delta;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        in_range;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_MOD,
        BK_ACCESS,
        BK_ROWCLR,
        BK_CLEAR,
        BK_RESP
    } back_state_t;

endpackage

>>> rtl/tcse_front.sv
module tcse_front #(
    parameter int COLUMNS     = 80,
    parameter int SCREEN_ROWS = 25
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic [7:0]         char_code,
    input  logic signed [12:0] scroll_delta,
    input  logic [7:0]         screen_col,
    input  logic [7:0]         disp_row,
    input  logic               init_busy,
    output logic               cmd_valid,
    output tcse_pkg::cmd_t     cmd,
    input  logic               cmd_pop
);
    import tcse_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       push;

    // classify the incoming word
    always_comb
    begin
        in_cmd.ch       = char_code;
        in_cmd.delta    = scroll_delta;
        in_cmd.col      = screen_col;
        in_cmd.row      = disp_row;
        in_cmd.in_range = (int'(screen_col) < COLUMNS) && (int'(disp_row) < SCREEN_ROWS);
        unique case (func)
            FUNC_PUT:    in_cmd.op = OP_PUT;
            FUNC_SCROLL: in_cmd.op = OP_SCROLL;
            FUNC_SETCUR: in_cmd.op = OP_SETCUR;
            FUNC_CLEAR:  in_cmd.op = OP_CLEAR;
            FUNC_READ:   in_cmd.op = OP_READ;
            default:     in_cmd.op = OP_NONE;
        endcase
    end

    assign busy      = (cnt_reg == 2'd2) || init_busy;
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    // two-entry command queue
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = cmd_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

>>> rtl/tcse_back.sv
module tcse_back #(
    parameter int COLUMNS      = 80,
    parameter int SCREEN_ROWS  = 25,
    parameter int HISTORY_ROWS = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     attr,
    input  logic           cmd_valid,
    input  tcse_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           init_busy,
    output logic           done,
    output logic [15:0]    cell_value,
    output logic           read_valid,
    output logic [6:0]     cursor_column,
    output logic [4:0]     cursor_screen_row,
    output logic [10:0]    cursor_position,
    output logic [7:0]     view_top_row
);
    import tcse_pkg::*;

    localparam int DEPTH = HISTORY_ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(HISTORY_ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int MW    = $clog2(2 * HISTORY_ROWS + 64);
    localparam int PSW   = $clog2(SCREEN_ROWS * COLUMNS + 1);

    back_state_t    state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  view_reg, view_next;
    logic [RW-1:0]  off_reg, off_next;
    logic [RW-1:0]  clr_row_reg, clr_row_next;
    logic [15:0]    fill_reg, fill_next;
    logic [AW-1:0]  sweep_reg, sweep_next;
    logic [CW-1:0]  ccnt_reg, ccnt_next;
    logic [MW-1:0]  phys_reg, phys_next;
    logic [CW-1:0]  wcol_reg, wcol_next;
    logic [15:0]    wdata_reg, wdata_next;
    logic           wr_reg, wr_next;
    logic           adv_reg, adv_next;
    logic           init_reg, init_next;

    logic           done_next;
    logic [15:0]    cell_next;
    logic           valid_next;
    logic [6:0]     ocol_next;
    logic [4:0]     osrow_next;
    logic [10:0]    opos_next;
    logic [7:0]     oview_next;

    logic [15:0]    mem [DEPTH];
    logic [15:0]    rdata_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [15:0]    mem_wdata;

    // first history row shown when the view sits at the bottom
    function automatic logic [RW-1:0] bottom_of(input logic [RW-1:0] r);
        int t;
        t = int'(r) + 1;
        return (t > SCREEN_ROWS) ? RW'(t - SCREEN_ROWS) : '0;
    endfunction

    assign init_busy = init_reg;

    // store port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = AW'(phys_reg[RW-1:0]) * AW'(COLUMNS) + AW'(wcol_reg);
        mem_wdata = wdata_reg;
        unique case (state_reg)
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = sweep_reg;
                mem_wdata = fill_reg;
            end
            BK_ROWCLR:
            begin
                mem_we    = 1'b1;
                mem_addr  = AW'(clr_row_reg) * AW'(COLUMNS) + AW'(ccnt_reg);
                mem_wdata = fill_reg;
            end
            BK_ACCESS: mem_we = wr_reg;
            default:   mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // sequencer
    always_comb
    begin
        logic [RW:0]          prow;
        logic [CW:0]          pcol;
        logic [RW:0]          wrow;
        logic                 dow;
        logic [7:0]           wch;
        logic                 adv;
        logic signed [15:0]   v;
        logic signed [15:0]   vmax;
        logic [MW-1:0]        r;
        logic                 on_view;
        logic [6:0]           srow;
        logic [PSW-1:0]       pos;

        state_next   = state_reg;
        cmd_next     = cmd_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        view_next    = view_reg;
        off_next     = off_reg;
        clr_row_next = clr_row_reg;
        fill_next    = fill_reg;
        sweep_next   = sweep_reg;
        ccnt_next    = ccnt_reg;
        phys_next    = phys_reg;
        wcol_next    = wcol_reg;
        wdata_next   = wdata_reg;
        wr_next      = wr_reg;
        adv_next     = adv_reg;
        init_next    = init_reg;
        cmd_pop      = 1'b0;
        done_next    = 1'b0;
        cell_next    = cell_value;
        valid_next   = read_valid;
        ocol_next    = cursor_column;
        osrow_next   = cursor_screen_row;
        opos_next    = cursor_position;
        oview_next   = view_top_row;

        prow    = {1'b0, row_reg};
        pcol    = {1'b0, col_reg};
        wrow    = prow;
        dow     = 1'b0;
        wch     = CH_SPACE;
        adv     = 1'b0;
        v       = '0;
        vmax    = '0;
        r       = '0;
        on_view = 1'b0;
        srow    = '0;
        pos     = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = BK_EXEC;
                end
            end

            BK_EXEC:
            begin
                adv_next   = 1'b0;
                wr_next    = 1'b0;
                ccnt_next  = '0;
                state_next = BK_RESP;
                unique case (cmd_reg.op)
                    OP_PUT:
                    begin
                        // move the cursor and pick the cell to write
                        priority case (cmd_reg.ch)
                            CH_NEWLINE:
                            begin
                                pcol = '0;
                                prow = prow + 1'b1;
                            end
                            CH_RETURN: pcol = '0;
                            CH_TAB:    pcol = (pcol + (CW+1)'(4)) & ~(CW+1)'(3);
                            CH_BACKSPACE:
                            begin
                                if (col_reg != '0)
                                begin
                                    pcol = pcol - 1'b1;
                                end
                                else if (row_reg != '0)
                                begin
                                    prow = prow - 1'b1;
                                    pcol = (CW+1)'(COLUMNS - 1);
                                end
                                dow = 1'b1;
                            end
                            default:
                            begin
                                dow = 1'b1;
                                wch = cmd_reg.ch;
                            end
                        endcase
                        wrow      = prow;
                        wcol_next = pcol[CW-1:0];
                        if (dow && cmd_reg.ch != CH_BACKSPACE)
                        begin
                            pcol = pcol + 1'b1;
                        end
                        // right edge wrap
                        if (int'(pcol) >= COLUMNS)
                        begin
                            pcol = '0;
                            prow = prow + 1'b1;
                        end
                        // ring full: drop the oldest row
                        if (int'(prow) >= HISTORY_ROWS)
                        begin
                            adv  = 1'b1;
                            prow = (RW+1)'(HISTORY_ROWS - 1);
                        end
                        row_next     = prow[RW-1:0];
                        col_next     = pcol[CW-1:0];
                        view_next    = bottom_of(prow[RW-1:0]);
                        adv_next     = adv;
                        clr_row_next = off_reg;
                        if (adv)
                        begin
                            off_next = (int'(off_reg) == HISTORY_ROWS - 1) ? '0
                                                                            : off_reg + 1'b1;
                        end
                        fill_next  = {attr, CH_SPACE};
                        phys_next  = MW'(off_reg) + MW'(wrow);
                        wdata_next = {attr, wch};
                        wr_next    = 1'b1;
                        if (dow)
                        begin
                            state_next = BK_MOD;
                        end
                        else if (adv)
                        begin
                            state_next = BK_ROWCLR;
                        end
                    end
                    OP_SCROLL:
                    begin
                        v    = $signed(16'(view_reg)) + 16'($signed(cmd_reg.delta));
                        vmax = $signed(16'(bottom_of(row_reg)));
                        if (v < 0)
                        begin
                            v = '0;
                        end
                        if (v > vmax)
                        begin
                            v = vmax;
                        end
                        view_next = v[RW-1:0];
                    end
                    OP_SETCUR:
                    begin
                        if (cmd_reg.in_range)
                        begin
                            r        = MW'(view_reg) + MW'(cmd_reg.row);
                            col_next = cmd_reg.col[CW-1:0];
                            row_next = (int'(r) >= HISTORY_ROWS) ? RW'(HISTORY_ROWS - 1)
                                                                 : r[RW-1:0];
                        end
                    end
                    OP_CLEAR:
                    begin
                        fill_next  = {attr, CH_SPACE};
                        sweep_next = '0;
                        row_next   = '0;
                        col_next   = '0;
                        view_next  = '0;
                        off_next   = '0;
                        state_next = BK_CLEAR;
                    end
                    OP_READ:
                    begin
                        if (cmd_reg.in_range)
                        begin
                            phys_next  = MW'(off_reg) + MW'(view_reg) + MW'(cmd_reg.row);
                            wcol_next  = cmd_reg.col[CW-1:0];
                            state_next = BK_MOD;
                        end
                    end
                    default: state_next = BK_RESP;
                endcase
            end

            // reduce the physical row modulo the ring size
            BK_MOD:
            begin
                if (int'(phys_reg) >= HISTORY_ROWS)
                begin
                    phys_next = phys_reg - MW'(HISTORY_ROWS);
                end
                else
                begin
                    state_next = BK_ACCESS;
                end
            end

            BK_ACCESS: state_next = (wr_reg && adv_reg) ? BK_ROWCLR : BK_RESP;

            BK_ROWCLR:
            begin
                ccnt_next = ccnt_reg + 1'b1;
                if (int'(ccnt_reg) == COLUMNS - 1)
                begin
                    state_next = BK_RESP;
                end
            end

            BK_CLEAR:
            begin
                sweep_next = sweep_reg + 1'b1;
                if (int'(sweep_reg) == DEPTH - 1)
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? BK_IDLE : BK_RESP;
                end
            end

            BK_RESP:
            begin
                on_view = (row_reg >= view_reg)
                       && (int'(row_reg) - int'(view_reg) < SCREEN_ROWS);
                if (on_view)
                begin
                    srow = 7'(row_reg - view_reg);
                    pos  = PSW'(srow) * PSW'(COLUMNS) + PSW'(col_reg);
                end
                else
                begin
                    srow = (row_reg < view_reg) ? '0 : 7'(SCREEN_ROWS - 1);
                    pos  = PSW'(SCREEN_ROWS * COLUMNS);
                end
                valid_next = (cmd_reg.op == OP_READ) && cmd_reg.in_range;
                cell_next  = valid_next ? rdata_reg : '0;
                ocol_next  = 7'(col_reg);
                osrow_next = 5'(srow);
                opos_next  = 11'(pos);
                oview_next = 8'(view_reg);
                done_next  = 1'b1;
                state_next = BK_IDLE;
            end

            default: state_next = BK_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            init_reg  <= 1'b1;
            sweep_reg <= '0;
            fill_reg  <= {ATTR_RESET, CH_SPACE};
            row_reg   <= '0;
            col_reg   <= '0;
            view_reg  <= '0;
            off_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            sweep_reg <= sweep_next;
            fill_reg  <= fill_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            view_reg  <= view_next;
            off_reg   <= off_next;
            done      <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        clr_row_reg       <= clr_row_next;
        ccnt_reg          <= ccnt_next;
        phys_reg          <= phys_next;
        wcol_reg          <= wcol_next;
        wdata_reg         <= wdata_next;
        wr_reg            <= wr_next;
        adv_reg           <= adv_next;
        cell_value        <= cell_next;
        read_valid        <= valid_next;
        cursor_column     <= ocol_next;
        cursor_screen_row <= osrow_next;
        cursor_position   <= opos_next;
        view_top_row      <= oview_next;
    end

endmodule

>>> rtl/text_console_scrollback_engine.sv
// Flow: scroll, set cursor, unused codes and out-of-range reads go from exec to response;
// reads and cell writes pass the modulo state (one step on the ring row), then access.
// A put that drops the oldest row also blanks that row; clear sweeps the whole store.
// The front queue holds two commands, so one is taken while the sequencer works on the last.
// Reset: a clearing pass blanks the store, busy held high.
// The done strobe lasts one cycle; the receiver cannot stall.
module text_console_scrollback_engine #(
    parameter int COLUMNS      = 80,
    parameter int SCREEN_ROWS  = 25,
    parameter int HISTORY_ROWS = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         func,
    input  logic [7:0]         char_code,
    input  logic signed [12:0] scroll_delta,
    input  logic [7:0]         screen_col,
    input  logic [7:0]         disp_row,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    output logic               done,
    output logic [15:0]        cell_value,
    output logic               read_valid,
    output logic [6:0]         cursor_column,
    output logic [4:0]         cursor_screen_row,
    output logic [10:0]        cursor_position,
    output logic [7:0]         view_top_row
);
    import tcse_pkg::*;

    logic [7:0] attr_reg, attr_next;
    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;
    logic       init_busy;

    // attribute register
    assign attr_next = cfg_we ? cfg_wdata : attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    tcse_front #(
        .COLUMNS     (COLUMNS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .char_code    (char_code),
        .scroll_delta (scroll_delta),
        .screen_col   (screen_col),
        .disp_row     (disp_row),
        .init_busy    (init_busy),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    tcse_back #(
        .COLUMNS      (COLUMNS),
        .SCREEN_ROWS  (SCREEN_ROWS),
        .HISTORY_ROWS (HISTORY_ROWS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .attr              (attr_reg),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cmd_pop           (cmd_pop),
        .init_busy         (init_busy),
        .done              (done),
        .cell_value        (cell_value),
        .read_valid        (read_valid),
        .cursor_column     (cursor_column),
        .cursor_screen_row (cursor_screen_row),
        .cursor_position   (cursor_position),
        .view_top_row      (view_top_row)
    );

    // the sequencer never produces two words in a row
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe on consecutive cycles");

    // no word while the reset clearing pass runs
    a_no_done_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !done)
        else $error("done during clearing pass");

    // a nonzero cell only comes with a valid read
    a_cell_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cell_value != 16'd0) |-> read_valid)
        else $error("cell value without valid read");

    // hidden cursor position is the screen size at most
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(cursor_position) <= SCREEN_ROWS * COLUMNS))
        else $error("cursor position out of range");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tcse_pkg::*;

    localparam int COLS   = 80;
    localparam int SROWS  = 25;
    localparam int HROWS  = 256;
    localparam int CELLS  = HROWS * COLS;
    localparam int CYCLE_LIMIT = 3000000;

    // codes the block treats as no operation
    localparam logic [2:0] FUNC_SPARE5 = 3'd5;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    typedef struct {
        logic [15:0] cval;
        logic        valid;
        logic [6:0]  col;
        logic [4:0]  srow;
        logic [10:0] pos;
        logic [7:0]  view;
    } status_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] func;
    logic [7:0] char_code;
    logic signed [12:0] scroll_delta;
    logic [7:0] screen_col;
    logic [7:0] disp_row;
    logic cfg_we;
    logic [7:0] cfg_wdata;
    logic done;
    logic [15:0] cell_value;
    logic read_valid;
    logic [6:0] cursor_column;
    logic [4:0] cursor_screen_row;
    logic [10:0] cursor_position;
    logic [7:0] view_top_row;

    text_console_scrollback_engine #(
        .COLUMNS(COLS),
        .SCREEN_ROWS(SROWS),
        .HISTORY_ROWS(HROWS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .char_code(char_code),
        .scroll_delta(scroll_delta),
        .screen_col(screen_col),
        .disp_row(disp_row),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .cell_value(cell_value),
        .read_valid(read_valid),
        .cursor_column(cursor_column),
        .cursor_screen_row(cursor_screen_row),
        .cursor_position(cursor_position),
        .view_top_row(view_top_row)
    );

    // console model state
    logic [15:0] screen_mem [CELLS];
    int unsigned ring_base;
    int unsigned cur_row;
    int unsigned cur_col;
    int unsigned view_row;
    logic [7:0]  attr;

    status_t     status_q[$];
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned ring_drops;
    int unsigned reads_hit;
    int unsigned cycles;
    int          gap_mode;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned mem_addr(int unsigned r, int unsigned c);
        return ((ring_base + r) % HROWS) * COLS + (c % COLS);
    endfunction

    function automatic logic [15:0] blank_cell();
        return {attr, CH_SPACE};
    endfunction

    function automatic int unsigned bottom_row();
        return (cur_row + 1 > SROWS) ? cur_row + 1 - SROWS : 0;
    endfunction

    task automatic wipe_console();
        for (int i = 0; i < CELLS; i++)
            screen_mem[i] = blank_cell();
        ring_base = 0;
        cur_row = 0;
        cur_col = 0;
        view_row = 0;
    endtask

    task automatic model_put(logic [7:0] ch);
        view_row = bottom_row();
        if (ch == CH_NEWLINE) begin
            cur_col = 0;
            cur_row++;
        end
        else if (ch == CH_RETURN)
            cur_col = 0;
        else if (ch == CH_TAB)
            cur_col = (cur_col + 4) & ~3;
        else if (ch == CH_BACKSPACE) begin
            if (cur_col > 0)
                cur_col--;
            else if (cur_row > 0) begin
                cur_row--;
                cur_col = COLS - 1;
            end
            screen_mem[mem_addr(cur_row, cur_col)] = blank_cell();
        end
        else begin
            screen_mem[mem_addr(cur_row, cur_col)] = {attr, ch};
            cur_col++;
        end
        if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
        end
        // history full: oldest row falls off, fresh blank row at the bottom
        if (cur_row >= HROWS) begin
            ring_base = (ring_base + 1) % HROWS;
            for (int i = 0; i < COLS; i++)
                screen_mem[mem_addr(HROWS - 1, i)] = blank_cell();
            cur_row = HROWS - 1;
            ring_drops++;
        end
        view_row = bottom_row();
    endtask

    // advance the console model by one command word and give its status
    task automatic console_step(input logic [2:0] f, input logic [7:0] ch,
                                input logic signed [12:0] dl, input logic [7:0] c,
                                input logic [7:0] r, output status_t st);
        int  v;
        int  maxv;
        bit  hit;
        hit = (c < COLS) && (r < SROWS);
        st.cval = '0;
        st.valid = 1'b0;
        case (f)
            FUNC_PUT: model_put(ch);
            FUNC_SCROLL: begin
                v = int'(view_row) + int'(dl);
                maxv = bottom_row();
                if (v < 0)
                    v = 0;
                if (v > maxv)
                    v = maxv;
                view_row = v;
            end
            FUNC_SETCUR: begin
                if (hit) begin
                    cur_col = c;
                    cur_row = (view_row + r >= HROWS) ? HROWS - 1 : view_row + r;
                end
            end
            FUNC_CLEAR: wipe_console();
            FUNC_READ: begin
                if (hit) begin
                    st.cval = screen_mem[mem_addr(view_row + r, c)];
                    st.valid = 1'b1;
                    reads_hit++;
                end
            end
            default: ;
        endcase
        if (cur_row >= view_row && cur_row - view_row < SROWS) begin
            st.srow = 5'(cur_row - view_row);
            st.pos = 11'((cur_row - view_row) * COLS + cur_col);
        end
        else begin
            st.srow = 5'((cur_row < view_row) ? 0 : SROWS - 1);
            st.pos = 11'(SROWS * COLS);
        end
        st.col = 7'(cur_col);
        st.view = 8'(view_row);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on word %0d, %s: expected %0d, got %0d",
                         words_checked, name, want, got);
        end
    endtask

    // compare every finished word with the oldest pending status
    always @(posedge clk) begin
        status_t want;
        if (rst_n && done) begin
            if (status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word, none pending");
            end
            else begin
                want = status_q.pop_front();
                check_field("cell_value", want.cval, cell_value);
                check_field("read_valid", want.valid, read_valid);
                check_field("cursor_column", want.col, cursor_column);
                check_field("cursor_screen_row", want.srow, cursor_screen_row);
                check_field("cursor_position", want.pos, cursor_position);
                check_field("view_top_row", want.view, view_top_row);
            end
            words_checked++;
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d words pending", status_q.size());
            $display("text_console_scrollback_engine test failed");
            $finish;
        end
    end

    task automatic idle_gap();
        int n;
        n = 0;
        if (gap_mode != 0) begin
            case ($urandom_range(9))
                0, 1, 2: n = $urandom_range(3, 1);
                3: n = $urandom_range(40, 8);
                default: n = 0;
            endcase
        end
        if (n > 0) begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // drive one command word and hold it until the block takes it
    task automatic send_word(logic [2:0] f, logic [7:0] ch, logic signed [12:0] dl,
                             logic [7:0] c, logic [7:0] r);
        status_t st;
        @(negedge clk);
        start = 1'b1;
        func = f;
        char_code = ch;
        scroll_delta = dl;
        screen_col = c;
        disp_row = r;
        while (busy)
            @(negedge clk);
        console_step(f, ch, dl, c, r, st);
        status_q.push_back(st);
        words_sent++;
        @(posedge clk);
        idle_gap();
    endtask

    task automatic put_ch(logic [7:0] ch);
        send_word(FUNC_PUT, ch, 13'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic read_at(logic [7:0] c, logic [7:0] r);
        send_word(FUNC_READ, 8'($urandom), 13'($urandom), c, r);
    endtask

    // wait for all pending words and for the sequencer to settle
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (status_q.size() != 0)
            @(negedge clk);
        repeat (COLS + 16) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_attr(logic [7:0] a);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = a;
        @(negedge clk);
        cfg_we = 1'b0;
        cfg_wdata = 8'($urandom);
        attr = a;
    endtask

    task automatic test_commands();
        gap_mode = 0;
        put_ch(8'h41);
        put_ch(8'h00);
        put_ch(8'hFF);
        put_ch(CH_TAB);
        put_ch(CH_RETURN);
        put_ch(CH_BACKSPACE);
        put_ch(CH_BACKSPACE);
        put_ch(CH_BACKSPACE);
        put_ch(CH_NEWLINE);
        // backspace at column 0 wraps to the end of the previous row
        put_ch(CH_BACKSPACE);
        send_word(FUNC_SETCUR, 0, 0, 8'(COLS - 1), 1);
        put_ch(8'h5A);
        read_at(8'(COLS - 1), 1);
        read_at(0, 0);
        read_at(8'(COLS - 1), 8'(SROWS - 1));
        read_at(8'(COLS), 0);
        read_at(0, 8'(SROWS));
        read_at(8'hFF, 8'hFF);
        send_word(FUNC_SCROLL, 0, -13'sd4096, 0, 0);
        send_word(FUNC_SCROLL, 0, 13'sd4095, 0, 0);
        send_word(FUNC_SETCUR, 0, 0, 8'(COLS), 3);
        send_word(FUNC_SETCUR, 0, 0, 3, 8'(SROWS));
        send_word(FUNC_SPARE5, 8'hFF, 13'sh1FFF, 8'hFF, 8'hFF);
        send_word(FUNC_SPARE6, 0, 0, 0, 0);
        send_word(FUNC_SPARE7, 0, 0, 0, 0);
        send_word(FUNC_CLEAR, 0, 0, 0, 0);
    endtask

    task automatic test_attributes();
        logic [7:0] vals [4];
        vals = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
        foreach (vals[i]) begin
            write_attr(vals[i]);
            gap_mode = i % 2;
            put_ch(8'($urandom));
            put_ch(CH_BACKSPACE);
            put_ch(8'h7E);
            read_at(0, 0);
            read_at(1, 0);
            if (i == 1)
                send_word(FUNC_CLEAR, 0, 0, 0, 0);
        end
        write_attr(ATTR_RESET);
    endtask

    // fill past the history depth so the ring drops its oldest rows
    task automatic test_history_wrap();
        gap_mode = 1;
        for (int i = 0; i < HROWS + 40; i++) begin
            put_ch(8'(8'h21 + (i % 90)));
            if ($urandom_range(3) == 0)
                put_ch(8'($urandom_range(126, 32)));
            put_ch(CH_NEWLINE);
        end
        send_word(FUNC_SCROLL, 0, -13'sd30, 0, 0);
        read_at(8'($urandom_range(COLS - 1)), 8'($urandom_range(SROWS - 1)));
        send_word(FUNC_SETCUR, 0, 0, 5, 8'(SROWS - 1));
        send_word(FUNC_SCROLL, 0, -13'sd4096, 0, 0);
        for (int i = 0; i < 8; i++)
            read_at(8'($urandom_range(3)), 8'($urandom_range(SROWS - 1)));
        put_ch(8'h40);
    endtask

    task automatic random_word();
        logic [7:0] ch;
        logic [7:0] c;
        logic [7:0] r;
        int k;
        ch = 8'($urandom);
        c = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(COLS - 1));
        r = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(SROWS - 1));
        k = $urandom_range(99);
        if (k < 45) begin
            case ($urandom_range(9))
                0, 1: ch = CH_NEWLINE;
                2: ch = CH_TAB;
                3: ch = CH_BACKSPACE;
                4: ch = CH_RETURN;
                default: ;
            endcase
            send_word(FUNC_PUT, ch, 13'($urandom), c, r);
        end
        else if (k < 58)
            send_word(FUNC_SCROLL, ch, ($urandom_range(1) != 0) ? 13'($urandom)
                      : 13'($signed($urandom_range(60)) - 30), c, r);
        else if (k < 70)
            send_word(FUNC_SETCUR, ch, 13'($urandom), c, r);
        else if (k < 94)
            send_word(FUNC_READ, ch, 13'($urandom), c, r);
        else if (k < 99)
            send_word(3'($urandom_range(7, 5)), ch, 13'($urandom), c, r);
        else
            send_word(FUNC_CLEAR, ch, 13'($urandom), c, r);
    endtask

    task automatic test_random();
        for (int i = 0; i < 850; i++) begin
            if (i % 220 == 0) begin
                write_attr((i == 440) ? 8'hFF : 8'($urandom));
                gap_mode = (i / 220) % 2;
            end
            random_word();
        end
        // pause until everything is back, then a last burst
        drain();
        gap_mode = 1;
        for (int i = 0; i < 60; i++)
            random_word();
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_PUT;
        char_code = '0;
        scroll_delta = '0;
        screen_col = '0;
        disp_row = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        ring_drops = 0;
        reads_hit = 0;
        cycles = 0;
        gap_mode = 0;
        attr = ATTR_RESET;
        wipe_console();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_commands();
        test_attributes();
        test_history_wrap();
        test_random();

        drain();
        repeat (COLS + 16) @(posedge clk);
        $display("sent %0d command words, checked %0d results", words_sent, words_checked);
        $display("history row drops %0d, in-range reads %0d", ring_drops, reads_hit);
        if (mismatches == 0 && status_q.size() == 0)
            $display("text_console_scrollback_engine test passed");
        else
            $display("text_console_scrollback_engine test failed");
        $finish;
    end

endmodule

>>> text_console_scrollback_engine.f
rtl/tcse_pkg.sv
rtl/tcse_front.sv
rtl/tcse_back.sv
rtl/text_console_scrollback_engine.sv
bench/testbench.sv
